/* rtl/core/battery_thermal_charge_governor_macros.svh */
// assertion macros for the battery thermal charge governor
`ifndef BATTERY_THERMAL_CHARGE_GOVERNOR_MACROS_SVH
`define BATTERY_THERMAL_CHARGE_GOVERNOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define BTCG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("btcg assertion failed");

// next-cycle implication, checked out of reset
`define BTCG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("btcg assertion failed");

`endif

/* rtl/core/btcg_pkg.sv */
// shared types, constants and band table of the battery thermal charge governor
package btcg_pkg;

  localparam int unsigned REDUCED_DIVIDER = 2;
  localparam logic [1:0] CONFIRM_COUNT = 2'd2;

  localparam logic signed [11:0] TEMP_RESET = 12'sd250;
  localparam logic signed [11:0] FILT_LO = 12'sd400;
  localparam logic signed [11:0] FILT_HI = 12'sd500;
  localparam logic signed [12:0] FILT_DIFF_LO = -13'sd20;
  localparam logic signed [12:0] FILT_DIFF_HI = 13'sd30;

  localparam logic [15:0] RST_REDUCED_FLOAT_MV = 16'd4100;
  localparam logic [11:0] RST_DEFAULT_CURRENT_MA = 12'd1000;
  localparam logic [11:0] RST_REDUCED_CURRENT_MA = 12'd450;

  localparam logic [3:0] BAND_COLD = 4'd0;
  localparam logic [3:0] BAND_NORMAL = 4'd4;
  localparam logic [3:0] BAND_HOT = 4'd8;
  localparam logic [3:0] BAND_COOL_BELOW = 4'd3;
  localparam logic [3:0] BAND_WARM_ABOVE = 4'd5;
  localparam logic [3:0] BAND_MID_ABOVE = 4'd1;
  localparam logic [3:0] BAND_MID_BELOW = 4'd7;

  localparam logic [1:0] CS_NORMAL = 2'd0;
  localparam logic [1:0] CS_REDUCED = 2'd1;
  localparam logic [1:0] CS_STOPPED = 2'd2;

  localparam logic [1:0] HL_GOOD = 2'd0;
  localparam logic [1:0] HL_OVERHEAT = 2'd1;
  localparam logic [1:0] HL_COLD = 2'd2;

  typedef enum logic [2:0] {
    CFG_FILTER_EN   = 3'd0,
    CFG_THERMAL_EN  = 3'd1,
    CFG_ALT_BANDS   = 3'd2,
    CFG_RED_FLOAT   = 3'd3,
    CFG_DEF_CURRENT = 3'd4,
    CFG_RED_CURRENT = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    GOV_NORMAL  = 3'b001,
    GOV_REDUCED = 3'b010,
    GOV_STOPPED = 3'b100
  } gov_state_e;

  typedef enum logic [2:0] {
    TR_NONE = 3'd0,
    TR_N_S  = 3'd1,
    TR_N_R  = 3'd2,
    TR_R_S  = 3'd3,
    TR_R_N  = 3'd4,
    TR_S_N  = 3'd5,
    TR_S_R  = 3'd6
  } trans_e;

  typedef struct packed {
    logic        filter_en;
    logic        thermal_en;
    logic        alt_bands;
    logic [15:0] reduced_float_mv;
    logic [11:0] default_current_ma;
    logic [11:0] reduced_fixed_current_ma;
  } cfg_t;

  typedef struct packed {
    logic signed [11:0] temp_decicelsius;
    logic               charger_present;
    logic [15:0]        request_float_mv;
    logic [11:0]        thermal_limit_ma;
    logic [11:0]        max_current_ma;
  } item_t;

  typedef struct packed {
    logic [1:0]  charge_state;
    logic [2:0]  transition_code;
    logic [15:0] float_mv;
    logic        charge_disable;
    logic [11:0] current_limit_ma;
    logic        limit_refresh;
    logic [1:0]  health;
    logic        ui_charging;
  } res_t;

  // inclusive upper limit of each band below the hottest, two boundary sets
  function automatic logic signed [11:0] band_top(input logic alt, input logic [2:0] idx);
    logic signed [11:0] top;
    case (idx)
      3'd0: top = 12'sd0;
      3'd1: top = 12'sd30;
      3'd2: top = 12'sd100;
      3'd3: top = alt ? 12'sd130 : 12'sd120;
      3'd4: top = alt ? 12'sd420 : 12'sd430;
      3'd5: top = 12'sd450;
      3'd6: top = alt ? 12'sd500 : 12'sd520;
      3'd7: top = alt ? 12'sd530 : 12'sd550;
      default: top = 12'sd0;
    endcase
    return top;
  endfunction

endpackage

/* rtl/core/btcg_cfg.sv */
// configuration register file
module btcg_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  output btcg_pkg::cfg_t      cfg_o
);

  btcg_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (btcg_pkg::cfg_idx_e'(cfg_index_i))
        btcg_pkg::CFG_FILTER_EN:   cfg_d.filter_en = cfg_data_i[0];
        btcg_pkg::CFG_THERMAL_EN:  cfg_d.thermal_en = cfg_data_i[0];
        btcg_pkg::CFG_ALT_BANDS:   cfg_d.alt_bands = cfg_data_i[0];
        btcg_pkg::CFG_RED_FLOAT:   cfg_d.reduced_float_mv = cfg_data_i;
        btcg_pkg::CFG_DEF_CURRENT: cfg_d.default_current_ma = cfg_data_i[11:0];
        btcg_pkg::CFG_RED_CURRENT: cfg_d.reduced_fixed_current_ma = cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.filter_en <= 1'b1;
      cfg_q.thermal_en <= 1'b1;
      cfg_q.alt_bands <= 1'b0;
      cfg_q.reduced_float_mv <= btcg_pkg::RST_REDUCED_FLOAT_MV;
      cfg_q.default_current_ma <= btcg_pkg::RST_DEFAULT_CURRENT_MA;
      cfg_q.reduced_fixed_current_ma <= btcg_pkg::RST_REDUCED_CURRENT_MA;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* rtl/core/btcg_band.sv */
// repeat filter and temperature band classifier
module btcg_band (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               update_i,
  input  logic               filter_en_i,
  input  logic               alt_bands_i,
  input  logic signed [11:0] temp_i,
  output logic [3:0]         band_o
);

  logic signed [11:0] prev_q, prev_d;
  logic [1:0]         rc_q, rc_d;
  logic signed [12:0] diff;
  logic [1:0]         rc_mid;
  logic signed [11:0] t_filt;
  logic signed [11:0] t_used;
  logic [7:0]         above;

  always_comb begin
    diff = {temp_i[11], temp_i} - {prev_q[11], prev_q};
    rc_mid = rc_q;
    t_filt = temp_i;
    rc_d = 2'd1;
    if (temp_i >= btcg_pkg::FILT_LO && temp_i <= btcg_pkg::FILT_HI &&
        diff > btcg_pkg::FILT_DIFF_LO && diff < btcg_pkg::FILT_DIFF_HI) begin
      if (temp_i == prev_q) begin
        rc_mid = rc_q + 2'd1;
      end
      if (rc_mid >= btcg_pkg::CONFIRM_COUNT) begin
        rc_d = 2'd1;
      end else begin
        rc_d = rc_mid;
        t_filt = prev_q;
      end
    end
    prev_d = t_filt;
    t_used = filter_en_i ? t_filt : temp_i;
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      above[i] = t_used > btcg_pkg::band_top(alt_bands_i, 3'(i));
    end
  end

  assign band_o = 4'($countones(above));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= btcg_pkg::TEMP_RESET;
      rc_q <= 2'd1;
    end else if (update_i && filter_en_i) begin
      prev_q <= prev_d;
      rc_q <= rc_d;
    end
  end

endmodule

/* rtl/core/btcg_gov.sv */
// charge governor state machine and result generation
module btcg_gov (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               update_i,
  input  btcg_pkg::cfg_t     cfg_i,
  input  btcg_pkg::item_t    item_i,
  input  logic [3:0]         band_i,
  output btcg_pkg::res_t     res_o
);

  btcg_pkg::gov_state_e state_q, state_d, state_mid;
  logic        seen_q, seen_d;
  logic [15:0] held_q, held_d;
  logic [11:0] last_q, last_d;
  logic        ui_q, ui_d;
  logic        force_upd;
  btcg_pkg::trans_e code;
  logic        extreme, warm, cool, normal, mid;
  logic [11:0] lim_div;
  logic [11:0] cur;
  logic [1:0]  cs;
  logic [1:0]  health;

  assign extreme = (band_i == btcg_pkg::BAND_COLD) || (band_i == btcg_pkg::BAND_HOT);
  assign warm = band_i > btcg_pkg::BAND_WARM_ABOVE;
  assign cool = band_i < btcg_pkg::BAND_COOL_BELOW;
  assign normal = band_i == btcg_pkg::BAND_NORMAL;
  assign mid = (band_i > btcg_pkg::BAND_MID_ABOVE) && (band_i < btcg_pkg::BAND_MID_BELOW);
  assign lim_div = item_i.max_current_ma / 12'(btcg_pkg::REDUCED_DIVIDER);

  always_comb begin
    seen_d = seen_q;
    state_mid = state_q;
    force_upd = 1'b0;
    held_d = held_q;
    if (seen_q != item_i.charger_present) begin
      seen_d = item_i.charger_present;
      if (item_i.charger_present) begin
        state_mid = btcg_pkg::GOV_NORMAL;
        force_upd = 1'b1;
      end
    end
    if (item_i.request_float_mv != cfg_i.reduced_float_mv) begin
      held_d = item_i.request_float_mv;
    end

    state_d = state_mid;
    ui_d = ui_q;
    code = btcg_pkg::TR_NONE;
    case (state_mid)
      btcg_pkg::GOV_NORMAL: begin
        if (extreme) begin
          code = btcg_pkg::TR_N_S;
          state_d = btcg_pkg::GOV_STOPPED;
          ui_d = 1'b0;
        end else if (warm || cool) begin
          code = btcg_pkg::TR_N_R;
          state_d = btcg_pkg::GOV_REDUCED;
          ui_d = 1'b1;
        end else begin
          ui_d = 1'b1;
        end
      end
      btcg_pkg::GOV_REDUCED: begin
        if (extreme) begin
          code = btcg_pkg::TR_R_S;
          state_d = btcg_pkg::GOV_STOPPED;
          ui_d = 1'b0;
        end else if (normal) begin
          code = btcg_pkg::TR_R_N;
          state_d = btcg_pkg::GOV_NORMAL;
          ui_d = 1'b1;
        end else begin
          ui_d = 1'b1;
        end
      end
      btcg_pkg::GOV_STOPPED: begin
        if (mid) begin
          if (normal) begin
            code = btcg_pkg::TR_S_N;
            state_d = btcg_pkg::GOV_NORMAL;
          end else begin
            code = btcg_pkg::TR_S_R;
            state_d = btcg_pkg::GOV_REDUCED;
          end
          ui_d = 1'b1;
        end else begin
          ui_d = 1'b0;
        end
      end
      default: ;
    endcase

    last_d = last_q;
    if (cfg_i.thermal_en) begin
      case (state_d)
        btcg_pkg::GOV_NORMAL:
          cur = (item_i.thermal_limit_ma <= item_i.max_current_ma) ?
                item_i.thermal_limit_ma : item_i.max_current_ma;
        btcg_pkg::GOV_REDUCED:
          cur = (item_i.thermal_limit_ma <= lim_div) ? item_i.thermal_limit_ma : lim_div;
        default:
          cur = cfg_i.default_current_ma;
      endcase
      if (last_q != cur) begin
        last_d = cur;
        force_upd = 1'b1;
      end
    end else begin
      cur = (state_d == btcg_pkg::GOV_REDUCED) ? cfg_i.reduced_fixed_current_ma :
            cfg_i.default_current_ma;
    end

    case (state_d)
      btcg_pkg::GOV_NORMAL:  cs = btcg_pkg::CS_NORMAL;
      btcg_pkg::GOV_REDUCED: cs = btcg_pkg::CS_REDUCED;
      btcg_pkg::GOV_STOPPED: cs = btcg_pkg::CS_STOPPED;
      default:               cs = btcg_pkg::CS_NORMAL;
    endcase

    if (band_i == btcg_pkg::BAND_HOT) begin
      health = btcg_pkg::HL_OVERHEAT;
    end else if (band_i == btcg_pkg::BAND_COLD) begin
      health = btcg_pkg::HL_COLD;
    end else begin
      health = btcg_pkg::HL_GOOD;
    end
  end

  always_comb begin
    res_o.charge_state = cs;
    res_o.transition_code = code;
    res_o.float_mv = (state_d == btcg_pkg::GOV_REDUCED && warm) ? cfg_i.reduced_float_mv :
                     held_d;
    res_o.charge_disable = state_d == btcg_pkg::GOV_STOPPED;
    res_o.current_limit_ma = cur;
    res_o.limit_refresh = force_upd;
    res_o.health = health;
    res_o.ui_charging = ui_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= btcg_pkg::GOV_NORMAL;
      seen_q <= 1'b0;
      held_q <= 16'd0;
      last_q <= 12'd0;
      ui_q <= 1'b0;
    end else if (update_i) begin
      state_q <= state_d;
      seen_q <= seen_d;
      held_q <= held_d;
      last_q <= last_d;
      ui_q <= ui_d;
    end
  end

endmodule

/* rtl/core/battery_thermal_charge_governor.sv */
// top level of the battery thermal charge governor
// usage:
//   input channel: in_valid_i / in_stall_o with one battery sample per transfer
//   output channel: out_valid_o / out_stall_i with one result per transfer
//   config channel: cfg_valid_i / cfg_ready_o, index and data; ready is always high,
//   write only while the block holds no item in flight
// path: a transferred sample is captured in the input register; its result is
//   computed from that register and loaded into the result register once that
//   register is empty or its result is being taken, and presented from then on
// throughput: one sample per cycle unless out_stall_i holds the result; the governor
//   state and the filter state update in the same cycle the result register loads
// stall: while the result waits, the input register still takes one more sample;
//   in_stall_o rises only when both registers are full and out_stall_i is high
// reset: config returns to defaults, the governor starts in normal with no
//   charger seen, the filter history is 25.0 C, both registers empty
`include "battery_thermal_charge_governor_macros.svh"

module battery_thermal_charge_governor (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [11:0] temp_decicelsius_i,
  input  logic               charger_present_i,
  input  logic [15:0]        request_float_mv_i,
  input  logic [11:0]        thermal_limit_ma_i,
  input  logic [11:0]        max_current_ma_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         charge_state_o,
  output logic [2:0]         transition_code_o,
  output logic [15:0]        float_mv_o,
  output logic               charge_disable_o,
  output logic [11:0]        current_limit_ma_o,
  output logic               limit_refresh_o,
  output logic [1:0]         health_o,
  output logic               ui_charging_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  btcg_pkg::cfg_t  cfg;
  btcg_pkg::item_t in_item_q;
  btcg_pkg::res_t  res, res_q;
  logic            in_valid_q, in_valid_d;
  logic            out_valid_q, out_valid_d;
  logic            in_xfer;
  logic            advance;
  logic [3:0]      band;

  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign in_xfer = in_valid_i && !in_stall_o;
  assign advance = in_valid_q && (!out_valid_q || !out_stall_i);

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = advance || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_item_q.temp_decicelsius <= temp_decicelsius_i;
      in_item_q.charger_present <= charger_present_i;
      in_item_q.request_float_mv <= request_float_mv_i;
      in_item_q.thermal_limit_ma <= thermal_limit_ma_i;
      in_item_q.max_current_ma <= max_current_ma_i;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  btcg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  btcg_band u_band (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .update_i    (advance),
    .filter_en_i (cfg.filter_en),
    .alt_bands_i (cfg.alt_bands),
    .temp_i      (in_item_q.temp_decicelsius),
    .band_o      (band)
  );

  btcg_gov u_gov (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .update_i (advance),
    .cfg_i    (cfg),
    .item_i   (in_item_q),
    .band_i   (band),
    .res_o    (res)
  );

  assign out_valid_o = out_valid_q;
  assign charge_state_o = res_q.charge_state;
  assign transition_code_o = res_q.transition_code;
  assign float_mv_o = res_q.float_mv;
  assign charge_disable_o = res_q.charge_disable;
  assign current_limit_ma_o = res_q.current_limit_ma;
  assign limit_refresh_o = res_q.limit_refresh;
  assign health_o = res_q.health;
  assign ui_charging_o = res_q.ui_charging;

  `BTCG_ASSERT_NOW(a_disable_match, out_valid_o, charge_disable_o == (charge_state_o == btcg_pkg::CS_STOPPED))
  `BTCG_ASSERT_NOW(a_stopped_no_ui, out_valid_o && charge_state_o == btcg_pkg::CS_STOPPED, !ui_charging_o)
  `BTCG_ASSERT_NOW(a_overheat_stops, out_valid_o && health_o == btcg_pkg::HL_OVERHEAT, charge_disable_o)
  `BTCG_ASSERT_NEXT(a_drain_empty, out_valid_o && !out_stall_i && !in_valid_q, !out_valid_o)

endmodule

/* verif/tb_battery_thermal_charge_governor.sv */
// testbench for the battery thermal charge governor: directed table plus random samples
module tb_battery_thermal_charge_governor;
  import btcg_pkg::*;

  localparam int HOLD_CYCLES = 64;
  localparam int QUIET_LIMIT = 2000;
  localparam int N_DIRECTED = 20;

  typedef struct packed {
    item_t stim;
    logic  typed;
    res_t  want;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [11:0] temp_decicelsius_i;
  logic               charger_present_i;
  logic [15:0]        request_float_mv_i;
  logic [11:0]        thermal_limit_ma_i;
  logic [11:0]        max_current_ma_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         charge_state_o;
  logic [2:0]         transition_code_o;
  logic [15:0]        float_mv_o;
  logic               charge_disable_o;
  logic [11:0]        current_limit_ma_o;
  logic               limit_refresh_o;
  logic [1:0]         health_o;
  logic               ui_charging_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i;
  logic [15:0]        cfg_data_i;

  battery_thermal_charge_governor dut (.*);

  // governor mirror
  cfg_t        m_cfg = '{1'b1, 1'b1, 1'b0, RST_REDUCED_FLOAT_MV, RST_DEFAULT_CURRENT_MA,
                         RST_REDUCED_CURRENT_MA};
  logic [1:0]  m_gov = CS_NORMAL;
  logic        m_charger = 1'b0;
  logic [15:0] m_held_fv = '0;
  int          m_prev_temp = 250;
  logic [1:0]  m_repeats = 2'd1;
  logic [11:0] m_last_ma = '0;
  logic        m_ui = 1'b0;

  int band_tops [2][8] = '{'{0, 30, 100, 120, 430, 450, 520, 550},
                           '{0, 30, 100, 130, 420, 450, 500, 530}};

  res_t  pending_charge_results [$];
  int    mismatches = 0;
  int    quiet_cycles = 0;
  bit    idle_tx = 1'b0;
  bit    idle_rx = 1'b0;
  bit    hold_req = 1'b0;
  int    last_temp = 250;
  item_t last_item = '0;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{'{12'sd250, 1'b1, 16'd4200, 12'd800, 12'd1500}, 1'b1,
      '{CS_NORMAL, TR_NONE, 16'd4200, 1'b0, 12'd800, 1'b1, HL_GOOD, 1'b1}},
    '{'{12'h800, 1'b1, 16'd4200, 12'd800, 12'd1500}, 1'b1,
      '{CS_STOPPED, TR_N_S, 16'd4200, 1'b1, 12'd1000, 1'b1, HL_COLD, 1'b0}},
    '{'{12'sd2047, 1'b1, 16'd4200, 12'd800, 12'd1500}, 1'b1,
      '{CS_STOPPED, TR_NONE, 16'd4200, 1'b1, 12'd1000, 1'b0, HL_OVERHEAT, 1'b0}},
    '{'{12'sd440, 1'b1, 16'd4100, 12'd4095, 12'd4095}, 1'b0, '0},
    '{'{12'sd530, 1'b1, 16'd0, 12'd4095, 12'd4095}, 1'b0, '0},
    '{'{12'sd300, 1'b1, 16'd65535, 12'd0, 12'd4095}, 1'b0, '0},
    '{'{12'sd30, 1'b1, 16'd1234, 12'd4095, 12'd0}, 1'b0, '0},
    '{'{12'sd0, 1'b1, 16'd4200, 12'd2000, 12'd3000}, 1'b0, '0},
    '{'{12'sd300, 1'b1, 16'd4200, 12'd2000, 12'd3000}, 1'b0, '0},
    '{'{12'sd300, 1'b0, 16'd4200, 12'd2000, 12'd3000}, 1'b0, '0},
    '{'{12'sd300, 1'b1, 16'd4200, 12'd2000, 12'd3000}, 1'b0, '0},
    '{'{12'sd450, 1'b1, 16'd4200, 12'd1500, 12'd1000}, 1'b0, '0},
    '{'{12'sd450, 1'b1, 16'd4200, 12'd1500, 12'd1000}, 1'b0, '0},
    '{'{12'sd460, 1'b1, 16'd4200, 12'd1500, 12'd1000}, 1'b0, '0},
    '{'{12'sd460, 1'b1, 16'd4200, 12'd1500, 12'd1000}, 1'b0, '0},
    '{'{12'sd480, 1'b1, 16'd4200, 12'd700, 12'd1000}, 1'b0, '0},
    '{'{12'sd470, 1'b1, 16'd4200, 12'd700, 12'd1000}, 1'b0, '0},
    '{'{12'sd520, 1'b1, 16'd4200, 12'd300, 12'd1000}, 1'b0, '0},
    '{'{12'sd521, 1'b1, 16'd4100, 12'd300, 12'd1000}, 1'b0, '0},
    '{'{12'sd551, 1'b1, 16'd4200, 12'd300, 12'd1000}, 1'b0, '0}
  };

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic res_t step_governor(input item_t it);
    res_t        r;
    int          t;
    int          d;
    int          band;
    logic [11:0] cur;
    logic [11:0] lim;
    logic        force_up;
    logic [2:0]  code;
    logic        extreme;
    logic        warm;
    logic        cool;
    logic        norm_band;
    logic        mid;
    force_up = 1'b0;
    code = TR_NONE;
    if (m_charger != it.charger_present) begin
      m_charger = it.charger_present;
      if (it.charger_present) begin
        m_gov = CS_NORMAL;
        force_up = 1'b1;
      end
    end
    if (it.request_float_mv != m_cfg.reduced_float_mv) m_held_fv = it.request_float_mv;
    t = int'($signed(it.temp_decicelsius));
    // readings in the 40 to 50 degree window, close to the last one, wait for a repeat
    if (m_cfg.filter_en) begin
      d = t - m_prev_temp;
      if (t >= 400 && t <= 500 && d > -20 && d < 30) begin
        if (t == m_prev_temp) m_repeats = m_repeats + 2'd1;
        if (m_repeats >= CONFIRM_COUNT) m_repeats = 2'd1;
        else t = m_prev_temp;
      end else begin
        m_repeats = 2'd1;
      end
      m_prev_temp = t;
    end
    band = 0;
    while (band < 8 && t > band_tops[m_cfg.alt_bands][band]) band++;
    extreme = (band == 0 || band == 8);
    warm = band > 5;
    cool = band < 3;
    norm_band = band == 4;
    mid = band > 1 && band < 7;
    case (m_gov)
      CS_NORMAL: begin
        if (extreme) begin
          code = TR_N_S;
          m_gov = CS_STOPPED;
          m_ui = 1'b0;
        end else if (warm || cool) begin
          code = TR_N_R;
          m_gov = CS_REDUCED;
          m_ui = 1'b1;
        end else begin
          m_ui = 1'b1;
        end
      end
      CS_REDUCED: begin
        if (extreme) begin
          code = TR_R_S;
          m_gov = CS_STOPPED;
          m_ui = 1'b0;
        end else if (norm_band) begin
          code = TR_R_N;
          m_gov = CS_NORMAL;
          m_ui = 1'b1;
        end else begin
          m_ui = 1'b1;
        end
      end
      CS_STOPPED: begin
        if (mid) begin
          code = norm_band ? TR_S_N : TR_S_R;
          m_gov = norm_band ? CS_NORMAL : CS_REDUCED;
          m_ui = 1'b1;
        end else begin
          m_ui = 1'b0;
        end
      end
      default: ;
    endcase
    r.float_mv = (m_gov == CS_REDUCED && warm) ? m_cfg.reduced_float_mv : m_held_fv;
    if (m_cfg.thermal_en) begin
      if (m_gov == CS_NORMAL) begin
        cur = (it.thermal_limit_ma <= it.max_current_ma) ? it.thermal_limit_ma
                                                          : it.max_current_ma;
      end else if (m_gov == CS_REDUCED) begin
        lim = (REDUCED_DIVIDER != 0) ? 12'(it.max_current_ma / REDUCED_DIVIDER)
                                     : it.max_current_ma;
        cur = (it.thermal_limit_ma <= lim) ? it.thermal_limit_ma : lim;
      end else begin
        cur = m_cfg.default_current_ma;
      end
      if (m_last_ma != cur) begin
        m_last_ma = cur;
        force_up = 1'b1;
      end
    end else begin
      cur = (m_gov == CS_REDUCED) ? m_cfg.reduced_fixed_current_ma : m_cfg.default_current_ma;
    end
    r.charge_state = m_gov;
    r.transition_code = code;
    r.charge_disable = (m_gov == CS_STOPPED);
    r.current_limit_ma = cur;
    r.limit_refresh = force_up;
    r.health = (band == 8) ? HL_OVERHEAT : ((band == 0) ? HL_COLD : HL_GOOD);
    r.ui_charging = m_ui;
    return r;
  endfunction

  task automatic send_item(input item_t it, input logic typed, input res_t typed_res);
    res_t predicted;
    int   gap;
    if (idle_tx && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    temp_decicelsius_i <= it.temp_decicelsius;
    charger_present_i <= it.charger_present;
    request_float_mv_i <= it.request_float_mv;
    thermal_limit_ma_i <= it.thermal_limit_ma;
    max_current_ma_i <= it.max_current_ma;
    do @(posedge clk_i); while (in_stall_o);
    predicted = step_governor(it);
    pending_charge_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_charge_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_FILTER_EN:   m_cfg.filter_en = val[0];
      CFG_THERMAL_EN:  m_cfg.thermal_en = val[0];
      CFG_ALT_BANDS:   m_cfg.alt_bands = val[0];
      CFG_RED_FLOAT:   m_cfg.reduced_float_mv = val;
      CFG_DEF_CURRENT: m_cfg.default_current_ma = val[11:0];
      CFG_RED_CURRENT: m_cfg.reduced_fixed_current_ma = val[11:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(input logic filt, input logic therm, input logic alt,
                           input logic [15:0] red_fv, input logic [11:0] def_ma,
                           input logic [11:0] red_ma);
    drain();
    write_reg(CFG_FILTER_EN, {15'd0, filt});
    write_reg(CFG_THERMAL_EN, {15'd0, therm});
    write_reg(CFG_ALT_BANDS, {15'd0, alt});
    write_reg(CFG_RED_FLOAT, red_fv);
    write_reg(CFG_DEF_CURRENT, {4'd0, def_ma});
    write_reg(CFG_RED_CURRENT, {4'd0, red_ma});
  endtask

  task automatic run_phase(input int count, input bit tx_gaps, input bit rx_gaps,
                           input bit squeeze);
    item_t it;
    int    t;
    idle_tx = tx_gaps;
    idle_rx = rx_gaps;
    hold_req = squeeze;
    it = last_item;
    repeat (count) begin
      // bias toward repeats, band edges and the filter window
      case ($urandom_range(0, 9))
        0, 1, 2: t = last_temp;
        3, 4:    t = last_temp + int'($urandom_range(0, 50)) - 25;
        5, 6:    t = band_tops[$urandom_range(0, 1)][$urandom_range(0, 7)]
                     + int'($urandom_range(0, 2)) - 1;
        7:       t = 380 + int'($urandom_range(0, 180));
        default: t = int'($urandom_range(0, 4095)) - 2048;
      endcase
      if (t < -2048 || t > 2047) t = last_temp;
      last_temp = t;
      it.temp_decicelsius = t[11:0];
      it.charger_present = ($urandom_range(0, 19) != 0);
      it.request_float_mv = ($urandom_range(0, 4) == 0) ? m_cfg.reduced_float_mv
                                                        : 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 1) == 0) begin
        it.thermal_limit_ma = 12'($urandom_range(0, 4095));
        it.max_current_ma = ($urandom_range(0, 7) == 0) ? it.thermal_limit_ma
                                                        : 12'($urandom_range(0, 4095));
      end
      send_item(it, 1'b0, '0);
    end
    last_item = it;
  endtask

  task automatic cmp_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s expected %0d actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // receiver side
  initial begin : rx_side
    int burst;
    burst = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else if (burst > 0) begin
        out_stall_i <= 1'b1;
        burst--;
      end else if (idle_rx && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 3);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_charge_results.size() == 0) begin
        $error("result transfer with no sample outstanding");
        mismatches++;
      end else begin
        want = pending_charge_results.pop_front();
        cmp_field("charge_state", want.charge_state, charge_state_o);
        cmp_field("transition_code", want.transition_code, transition_code_o);
        cmp_field("float_mv", want.float_mv, float_mv_o);
        cmp_field("charge_disable", want.charge_disable, charge_disable_o);
        cmp_field("current_limit_ma", want.current_limit_ma, current_limit_ma_o);
        cmp_field("limit_refresh", want.limit_refresh, limit_refresh_o);
        cmp_field("health", want.health, health_o);
        cmp_field("ui_charging", want.ui_charging, ui_charging_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    temp_decicelsius_i = '0;
    charger_present_i = 1'b0;
    request_float_mv_i = '0;
    thermal_limit_ma_i = '0;
    max_current_ma_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_FILTER_EN;
    cfg_data_i = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    idle_tx = 1'b1;
    idle_rx = 1'b1;
    foreach (directed_rows[i])
      send_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
    configure(1'b0, 1'b0, 1'b1, 16'd0, 12'd0, 12'd0);
    run_phase(300, 1'b1, 1'b1, 1'b0);
    configure(1'b1, 1'b1, 1'b1, 16'hFFFF, 12'hFFF, 12'hFFF);
    run_phase(400, 1'b1, 1'b1, 1'b1);
    configure(1'b1, 1'b0, 1'b0, 16'($urandom_range(0, 65535)),
              12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
    run_phase(400, 1'b1, 1'b1, 1'b0);
    configure(1'b1, 1'b1, 1'b0, RST_REDUCED_FLOAT_MV, RST_DEFAULT_CURRENT_MA,
              RST_REDUCED_CURRENT_MA);
    run_phase(500, 1'b1, 1'b1, 1'b0);
    configure(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              16'($urandom_range(0, 65535)), 12'($urandom_range(0, 4095)),
              12'($urandom_range(0, 4095)));
    // no gaps on either side from here on
    run_phase(400, 1'b0, 1'b0, 1'b0);
    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/btcg_pkg.sv
rtl/core/btcg_cfg.sv
rtl/core/btcg_band.sv
rtl/core/btcg_gov.sv
rtl/core/battery_thermal_charge_governor.sv
verif/tb_battery_thermal_charge_governor.sv
